// ----- rtl/arfb_pkg.sv -----
// Shared types, register indexes and arithmetic helpers for the alpha
// rectangle fill blend core. No dependencies.
package arfb_pkg;

  localparam int unsigned MAX_CANVAS_SIDE = 4096;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t REG_CANVAS_WIDTH  = 3'd0;
  localparam cfg_idx_t REG_CANVAS_HEIGHT = 3'd1;
  localparam cfg_idx_t REG_RECT_LEFT     = 3'd2;
  localparam cfg_idx_t REG_RECT_TOP      = 3'd3;
  localparam cfg_idx_t REG_RECT_WIDTH    = 3'd4;
  localparam cfg_idx_t REG_RECT_HEIGHT   = 3'd5;
  localparam cfg_idx_t REG_FILL_COLOR    = 3'd6;

  localparam logic [12:0] CANVAS_WIDTH_RST  = 13'd1024;
  localparam logic [12:0] CANVAS_HEIGHT_RST = 13'd768;

  // Configuration as seen by the datapath; canvas sides already clamped.
  typedef struct packed {
    logic        [12:0] canvas_w;
    logic        [12:0] canvas_h;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] width;
    logic signed [15:0] height;
    logic        [31:0] fill;
  } cfg_view_t;

  // Payload leaving the clip stage.
  typedef struct packed {
    logic        hit;
    logic [31:0] old_pixel;
  } clip_data_t;

  function automatic logic [12:0] clamp_side(input logic [12:0] s);
    if (32'(s) > MAX_CANVAS_SIDE) begin
      return 13'(MAX_CANVAS_SIDE);
    end
    return s;
  endfunction

  // True when p lies in [start, start+len) and in [0, side).
  function automatic logic in_span(input logic [11:0] p, input logic signed [15:0] start,
                                   input logic signed [15:0] len, input logic [12:0] side);
    logic signed [17:0] ps;
    logic signed [17:0] ss;
    logic signed [17:0] es;
    ps = {6'b0, p};
    ss = {{2{start[15]}}, start};
    es = ss + {{2{len[15]}}, len};
    return !len[15] && (len != 16'sd0) && (ps >= ss) && (ps < es) && ({1'b0, p} < side);
  endfunction

  // c*a + o*(255-a) for one 8-bit channel; at most 255*255.
  function automatic logic [15:0] mix_sum(input logic [7:0] c, input logic [7:0] o,
                                          input logic [7:0] a);
    logic [7:0] ia;
    ia = 8'd255 - a;
    return 16'({8'b0, c} * {8'b0, a}) + 16'({8'b0, o} * {8'b0, ia});
  endfunction

  // Exact truncating x / 255 for any x up to 255*255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ----- rtl/arfb_in_if.sv -----
// Pixel input channel: valid/ready handshake with coordinates and old pixel.
// No dependencies.
interface arfb_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [31:0] old_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output old_pixel,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input old_pixel,
                  output ready);
endinterface

// ----- rtl/arfb_out_if.sv -----
// Result channel: valid/ready handshake with the new pixel and written flag.
// No dependencies.
interface arfb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_pixel;
  logic        written;

  modport source (output valid, output new_pixel, output written, input ready);
  modport sink   (input valid, input new_pixel, input written, output ready);
endinterface

// ----- rtl/arfb_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and write data.
// No dependencies.
interface arfb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/arfb_cfg_regs.sv -----
// Configuration register file of the blend core.
// Depends on arfb_pkg and arfb_cfg_if.
module arfb_cfg_regs import arfb_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  arfb_cfg_if.sink       cfg_ch,
  output cfg_view_t      view
);

  cfg_view_t view_r;
  cfg_view_t view_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    view_nxt = view_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_CANVAS_WIDTH:  view_nxt.canvas_w = clamp_side(cfg_ch.data[12:0]);
        REG_CANVAS_HEIGHT: view_nxt.canvas_h = clamp_side(cfg_ch.data[12:0]);
        REG_RECT_LEFT:     view_nxt.left     = cfg_ch.data[15:0];
        REG_RECT_TOP:      view_nxt.top      = cfg_ch.data[15:0];
        REG_RECT_WIDTH:    view_nxt.width    = cfg_ch.data[15:0];
        REG_RECT_HEIGHT:   view_nxt.height   = cfg_ch.data[15:0];
        REG_FILL_COLOR:    view_nxt.fill     = cfg_ch.data;
        default: ;  // drop writes past the last register
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r.canvas_w <= clamp_side(CANVAS_WIDTH_RST);
      view_r.canvas_h <= clamp_side(CANVAS_HEIGHT_RST);
      view_r.left     <= '0;
      view_r.top      <= '0;
      view_r.width    <= '0;
      view_r.height   <= '0;
      view_r.fill     <= '0;
    end else begin
      view_r <= view_nxt;
    end
  end

  assign view = view_r;

endmodule

// ----- rtl/arfb_clip.sv -----
// Stage 1: rectangle/canvas clip test, zero fill alpha check and input register.
// Depends on arfb_pkg and arfb_in_if.
module arfb_clip import arfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  arfb_in_if.sink    in_ch,
  input  cfg_view_t  cfg,
  input  logic       s1_ready,
  output logic       s1_valid,
  output clip_data_t s1_data
);

  logic       v1_r;
  logic       v1_nxt;
  clip_data_t d1_r;
  clip_data_t d1_nxt;
  logic       en1;

  assign en1         = !v1_r || s1_ready;
  assign in_ch.ready = en1;
  assign v1_nxt      = en1 ? in_ch.valid : v1_r;

  always_comb begin
    d1_nxt.old_pixel = in_ch.old_pixel;
    d1_nxt.hit       = (cfg.fill[31:24] != 8'd0)
                    && in_span(in_ch.pixel_x, cfg.left, cfg.width, cfg.canvas_w)
                    && in_span(in_ch.pixel_y, cfg.top, cfg.height, cfg.canvas_h);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d1_r <= d1_nxt;
    end
  end

  assign s1_valid = v1_r;
  assign s1_data  = d1_r;

endmodule

// ----- rtl/arfb_blend.sv -----
// Stages 2 and 3: per-channel products, then divide by 255 and select.
// Depends on arfb_pkg and arfb_out_if.
module arfb_blend import arfb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s1_valid,
  input  clip_data_t  s1_data,
  input  logic [31:0] fill_color,
  output logic        s1_ready,
  arfb_out_if.source  out_ch
);

  logic        v2_r, v2_nxt;
  logic        v3_r, v3_nxt;
  logic        en2, en3;

  logic        hit2_r;
  logic [31:0] old2_r;
  logic [15:0] mix_a_r, mix_a_nxt;
  logic [15:0] mix_r_r, mix_r_nxt;
  logic [15:0] mix_g_r, mix_g_nxt;
  logic [15:0] mix_b_r, mix_b_nxt;

  logic [31:0] pix3_r, pix3_nxt;
  logic        wr3_r;

  logic [7:0]  fa;
  logic [7:0]  inv_oa;

  assign en3      = !v3_r || out_ch.ready;
  assign en2      = !v2_r || en3;
  assign s1_ready = en2;
  assign v2_nxt   = en2 ? s1_valid : v2_r;
  assign v3_nxt   = en3 ? v2_r : v3_r;

  assign fa     = fill_color[31:24];
  assign inv_oa = 8'd255 - s1_data.old_pixel[31:24];

  always_comb begin
    mix_a_nxt = 16'({8'b0, inv_oa} * {8'b0, fa});
    mix_r_nxt = mix_sum(fill_color[23:16], s1_data.old_pixel[23:16], fa);
    mix_g_nxt = mix_sum(fill_color[15:8], s1_data.old_pixel[15:8], fa);
    mix_b_nxt = mix_sum(fill_color[7:0], s1_data.old_pixel[7:0], fa);
  end

  always_comb begin
    if (hit2_r) begin
      pix3_nxt = {old2_r[31:24] + div255(mix_a_r), div255(mix_r_r),
                  div255(mix_g_r), div255(mix_b_r)};
    end else begin
      pix3_nxt = old2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      hit2_r  <= s1_data.hit;
      old2_r  <= s1_data.old_pixel;
      mix_a_r <= mix_a_nxt;
      mix_r_r <= mix_r_nxt;
      mix_g_r <= mix_g_nxt;
      mix_b_r <= mix_b_nxt;
    end
    if (en3) begin
      pix3_r <= pix3_nxt;
      wr3_r  <= hit2_r;
    end
  end

  assign out_ch.valid     = v3_r;
  assign out_ch.new_pixel = pix3_r;
  assign out_ch.written   = wr3_r;

endmodule

// ----- rtl/alpha_rect_fill_blend_core.sv -----
// Top level of the ARGB8888 alpha rectangle fill blend core.
// Depends on arfb_pkg, the three channel interfaces, arfb_cfg_regs,
// arfb_clip and arfb_blend.
//
//  channel  | direction | transaction payload
//  ---------+-----------+--------------------------------------------
//  in_ch    | sink      | pixel_x[11:0], pixel_y[11:0], old_pixel[31:0]
//  out_ch   | source    | new_pixel[31:0], written
//  cfg_ch   | sink      | index[2:0], data[31:0]
//
// One pixel per clock sustained while out_ch is ready; each transaction passes
// from input acceptance to a valid result through the register stages clip test,
// channel multiply, and divide by 255 with output select.
// rst_n is synchronous and active low; it empties the pipeline and loads the
// register reset values. A stall on out_ch holds the output stage and each
// occupied stage behind a held one while empty stages fill; cfg_ch is always ready.
module alpha_rect_fill_blend_core import arfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  arfb_in_if.sink    in_ch,
  arfb_out_if.source out_ch,
  arfb_cfg_if.sink   cfg_ch
);

  cfg_view_t  cfg_view;
  logic       s1_valid;
  logic       s1_ready;
  clip_data_t s1_data;

  // Register file: canvas sides are clamped as they are written.
  arfb_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .view   (cfg_view)
  );

  // Stage 1: decide whether the pixel falls inside the clipped rectangle with a nonzero fill alpha.
  arfb_clip u_clip (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg_view),
    .s1_ready (s1_ready),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  // Stages 2 and 3: blend math and the output register.
  arfb_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_data    (s1_data),
    .fill_color (cfg_view.fill),
    .s1_ready   (s1_ready),
    .out_ch     (out_ch)
  );

endmodule

// ----- rtl/arfb_checker.sv -----
// Port-level assertions for the blend core, attached by bind.
// Depends on alpha_rect_fill_blend_core.
module arfb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_new_pixel,
  input logic        out_written,
  input logic        cfg_ready
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_pixel) && $stable(out_written))
    else $error("stalled result changed");

  // A free output side lets the input side take a transaction.
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output side is free");

  // An accepted transaction reaches the output when the output side does not stall.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after three cycles");

  // Configuration writes never stall.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind alpha_rect_fill_blend_core arfb_checker u_arfb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_new_pixel (out_ch.new_pixel),
  .out_written   (out_ch.written),
  .cfg_ready     (cfg_ch.ready)
);

// ----- bench/alpha_rect_fill_blend_core_tb.sv -----
// Self-checking testbench for alpha_rect_fill_blend_core: directed and random
// pixel streams under several register settings, checked against a predictor.
// Depends on arfb_pkg, the three channel interfaces and the core itself.
module alpha_rect_fill_blend_core_tb;
  import arfb_pkg::*;

  localparam int LIMIT       = 2000;  // cycles without any transaction
  localparam int HOLD_CYCLES = 40;    // long receiver hold-off
  localparam int DRAIN_TAIL  = 8;     // pipeline depth plus margin
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 50;

  localparam cfg_idx_t REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [31:0] pixel;
    logic        written;
  } blend_result_t;

  // Tracks the register file and holds the predicted pixels in order.
  class blend_scoreboard;
    logic        [12:0] canvas_w;
    logic        [12:0] canvas_h;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] width;
    logic signed [15:0] height;
    logic        [31:0] fill;
    blend_result_t      expected_pixels[$];
    int                 errors;

    function new();
      canvas_w = CANVAS_WIDTH_RST;
      canvas_h = CANVAS_HEIGHT_RST;
      left     = '0;
      top      = '0;
      width    = '0;
      height   = '0;
      fill     = '0;
      errors   = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] data);
      case (idx)
        REG_CANVAS_WIDTH:  canvas_w = data[12:0];
        REG_CANVAS_HEIGHT: canvas_h = data[12:0];
        REG_RECT_LEFT:     left     = data[15:0];
        REG_RECT_TOP:      top      = data[15:0];
        REG_RECT_WIDTH:    width    = data[15:0];
        REG_RECT_HEIGHT:   height   = data[15:0];
        REG_FILL_COLOR:    fill     = data;
        default: ;
      endcase
    endfunction

    function bit covers(int p, int start, int len, logic [12:0] side);
      int lim;
      lim = int'(side);
      if (lim > int'(MAX_CANVAS_SIDE)) lim = int'(MAX_CANVAS_SIDE);
      if (len <= 0) return 1'b0;
      return (p >= start) && (p < start + len) && (p < lim) && (p >= 0);
    endfunction

    function logic [7:0] mix(int c, int o, int a);
      return 8'((c * a + o * (255 - a)) / 255);
    endfunction

    function blend_result_t blend_pixel(logic [11:0] x, logic [11:0] y, logic [31:0] old);
      blend_result_t r;
      int a;
      int oa;
      a  = int'(fill[31:24]);
      oa = int'(old[31:24]);
      r.pixel   = old;
      r.written = 1'b0;
      if (a != 0 && covers(int'(x), int'(left), int'(width), canvas_w) &&
          covers(int'(y), int'(top), int'(height), canvas_h)) begin
        r.pixel[31:24] = 8'(oa + ((255 - oa) * a) / 255);
        r.pixel[23:16] = mix(int'(fill[23:16]), int'(old[23:16]), a);
        r.pixel[15:8]  = mix(int'(fill[15:8]), int'(old[15:8]), a);
        r.pixel[7:0]   = mix(int'(fill[7:0]), int'(old[7:0]), a);
        r.written      = 1'b1;
      end
      return r;
    endfunction

    function void note_pixel(logic [11:0] x, logic [11:0] y, logic [31:0] old);
      expected_pixels.push_back(blend_pixel(x, y, old));
    endfunction

    function void check_pixel(logic [31:0] pixel, logic written);
      blend_result_t e;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: new_pixel %h written %b", pixel, written);
        errors++;
        return;
      end
      e = expected_pixels.pop_front();
      if (pixel !== e.pixel) begin
        $error("new_pixel: expected %h, actual %h", e.pixel, pixel);
        errors++;
      end
      if (written !== e.written) begin
        $error("written: expected %b, actual %b", e.written, written);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   hold_req;  // ask the receiver for one long hold-off
  bit   no_idle;   // stop idling on both sides

  blend_scoreboard sb;

  arfb_in_if  in_ch();
  arfb_out_if out_ch();
  arfb_cfg_if cfg_ch();

  alpha_rect_fill_blend_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Observe every channel at the rising edge; inputs only move at the falling edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_pixel(in_ch.pixel_x, in_ch.pixel_y, in_ch.old_pixel);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_pixel(out_ch.new_pixel, out_ch.written);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.write_reg(cfg_ch.index, cfg_ch.data);
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when told.
  initial begin
    int burst;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // Hold ready low long enough for the pipeline to back up into in_ch.
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        burst = $urandom_range(1, 6);
        out_ch.ready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end
    end
  end

  // Watchdog: end the run when no transaction moves any more.
  initial begin
    int dead_cycles;
    dead_cycles = 0;
    while (dead_cycles < LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        dead_cycles = 0;
      end else begin
        dead_cycles++;
      end
    end
    $display("alpha_rect_fill_blend_core_tb: errors");
    $finish;
  end

  // Offer one pixel, maybe after an idle burst, and hold it until accepted.
  // Leave valid high on return so back-to-back pixels never drop it.
  task automatic send_pixel(input logic [11:0] x, input logic [11:0] y,
                            input logic [31:0] old);
    int gap;
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pixel_x   <= x;
    in_ch.pixel_y   <= y;
    in_ch.old_pixel <= old;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait for every predicted pixel to come back.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write one register; only call while the pipeline is empty.
  task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_rect(input logic [15:0] l, input logic [15:0] t,
                          input logic [15:0] w, input logic [15:0] h);
    cfg_write(REG_RECT_LEFT, {16'($urandom), l});
    cfg_write(REG_RECT_TOP, {16'($urandom), t});
    cfg_write(REG_RECT_WIDTH, {16'($urandom), w});
    cfg_write(REG_RECT_HEIGHT, {16'($urandom), h});
  endtask

  // Canvas side biased toward small sizes, with the clamp range covered.
  function automatic int pick_side();
    case ($urandom_range(0, 7))
      0:       return 1;
      1:       return 4096;
      2:       return $urandom_range(4097, 8191);
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  function automatic logic [15:0] pick_origin(int eff);
    if ($urandom_range(0, 5) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, eff + 8)) - 8);
  endfunction

  function automatic logic [15:0] pick_extent(int eff);
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return 16'd0;
      default: return 16'($urandom_range(1, eff + 8));
    endcase
  endfunction

  // Mostly near the canvas, sometimes anywhere in the 12-bit range.
  function automatic logic [11:0] pick_coord(int eff);
    if ($urandom_range(0, 3) == 0) return 12'($urandom);
    return 12'($urandom_range(0, (eff + 8 > 4095) ? 4095 : eff + 8));
  endfunction

  initial begin
    int          w_side;
    int          h_side;
    int          w_eff;
    int          h_eff;
    logic [31:0] fill;
    logic [31:0] old;

    sb = new();
    rst_n            = 1'b0;
    hold_req         = 1'b0;
    no_idle          = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.pixel_x    = '0;
    in_ch.pixel_y    = '0;
    in_ch.old_pixel  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_CANVAS_WIDTH;
    cfg_ch.data      = '0;

    // Hold reset, then release it at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: zero fill alpha, every pixel passes through.
    send_pixel(12'd0, 12'd0, 32'h0000_0000);
    send_pixel(12'hfff, 12'hfff, 32'hffff_ffff);
    wait_drained();

    // Rectangle hanging off the top-left corner of a 20x10 canvas.
    cfg_write(REG_CANVAS_WIDTH, 32'd20);
    cfg_write(REG_CANVAS_HEIGHT, 32'd10);
    set_rect(-16'sd3, -16'sd2, 16'sd10, 16'sd8);
    cfg_write(REG_FILL_COLOR, 32'h80ff_0040);
    send_pixel(12'd0, 12'd0, 32'h0000_0000);
    send_pixel(12'd6, 12'd5, 32'hffff_ffff);
    send_pixel(12'd7, 12'd5, 32'h1234_5678);
    send_pixel(12'd6, 12'd6, 32'h8765_4321);
    send_pixel(12'd19, 12'd9, 32'hdead_beef);
    send_pixel(12'hfff, 12'd0, 32'h5a5a_5a5a);
    send_pixel(12'd0, 12'hfff, 32'ha5a5_a5a5);
    send_pixel(12'd3, 12'd3, 32'h1234_5678);
    wait_drained();

    // Opaque fill, then the faintest nonzero alpha.
    cfg_write(REG_FILL_COLOR, 32'hff12_3456);
    send_pixel(12'd1, 12'd1, 32'ha5a5_a5a5);
    send_pixel(12'd6, 12'd0, 32'h0000_0000);
    wait_drained();
    cfg_write(REG_FILL_COLOR, 32'h01ff_ffff);
    send_pixel(12'd2, 12'd2, 32'h0000_0000);
    wait_drained();

    // Empty rectangles: zero width, most negative width, negative height.
    set_rect(16'sd0, 16'sd0, 16'sd0, 16'sd8);
    send_pixel(12'd0, 12'd0, 32'h0102_0304);
    wait_drained();
    cfg_write(REG_RECT_WIDTH, 32'h0000_8000);
    send_pixel(12'd0, 12'd0, 32'h0102_0304);
    wait_drained();
    cfg_write(REG_RECT_WIDTH, 32'd10);
    cfg_write(REG_RECT_HEIGHT, 32'h0000_ffff);
    send_pixel(12'd1, 12'd1, 32'h0102_0304);
    wait_drained();

    // Zero canvas width blends nothing.
    cfg_write(REG_CANVAS_WIDTH, 32'd0);
    cfg_write(REG_RECT_HEIGHT, 32'd8);
    send_pixel(12'd0, 12'd0, 32'h0000_0000);
    wait_drained();

    // Oversized canvas clamps to the maximum side; huge rectangle covers it.
    cfg_write(REG_CANVAS_WIDTH, 32'h0000_1fff);
    cfg_write(REG_CANVAS_HEIGHT, 32'h0000_1fff);
    set_rect(16'sd0, 16'sd0, 16'sh7fff, 16'sh7fff);
    cfg_write(REG_FILL_COLOR, 32'h7f00_80ff);
    send_pixel(12'hfff, 12'hfff, 32'h00ff_ff00);
    send_pixel(12'd0, 12'd0, 32'hffff_ffff);
    send_pixel(12'd2048, 12'd100, 32'h4080_c0ff);
    wait_drained();

    // Extreme origins: far right start, and a span ending just left of zero.
    cfg_write(REG_RECT_LEFT, 32'h0000_7fff);
    send_pixel(12'hfff, 12'd0, 32'h1111_1111);
    wait_drained();
    cfg_write(REG_RECT_LEFT, 32'h0000_8000);
    send_pixel(12'd0, 12'd0, 32'h2222_2222);
    wait_drained();

    // A write past the last register must change nothing.
    cfg_write(REG_RECT_LEFT, 32'd0);
    cfg_write(REG_UNUSED, 32'h0000_0000);
    send_pixel(12'd5, 12'd5, 32'h3333_3333);
    wait_drained();

    // Random phases: a fresh setting each time, written only once drained.
    for (int phase = 0; phase < PHASES; phase++) begin
      w_side = pick_side();
      h_side = pick_side();
      w_eff  = (w_side > 4096) ? 4096 : w_side;
      h_eff  = (h_side > 4096) ? 4096 : h_side;
      case ($urandom_range(0, 4))
        0:       fill = {8'd0, 24'($urandom)};
        1:       fill = {8'd255, 24'($urandom)};
        2:       fill = {8'd1, 24'($urandom)};
        default: fill = $urandom;
      endcase
      cfg_write(REG_CANVAS_WIDTH, {19'($urandom), 13'(w_side)});
      cfg_write(REG_CANVAS_HEIGHT, {19'($urandom), 13'(h_side)});
      set_rect(pick_origin(w_eff), pick_origin(h_eff), pick_extent(w_eff),
               pick_extent(h_eff));
      cfg_write(REG_FILL_COLOR, fill);
      if ($urandom_range(0, 2) == 0) cfg_write(REG_UNUSED, $urandom);

      // Stall the receiver for a long stretch while pixels keep coming.
      if (phase == 2) hold_req = 1'b1;
      // Keep the tail of the run free of idling on both sides.
      if (phase >= PHASES - 2) no_idle = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 15))
          0:       old = 32'h0000_0000;
          1:       old = 32'hffff_ffff;
          default: old = $urandom;
        endcase
        send_pixel(pick_coord(w_eff), pick_coord(h_eff), old);
        // Pause mid-phase until every result is back.
        if (phase == 5 && n == PHASE_ITEMS / 2) wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN_TAIL) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("alpha_rect_fill_blend_core_tb: clean");
    end else begin
      $display("alpha_rect_fill_blend_core_tb: errors");
    end
    $finish;
  end

endmodule
